// ===== hw/rtl/ncc_pkg.sv =====
// ncc_pkg: shared types, constants and helpers for the texel decoder.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package ncc_pkg;

    localparam int LUMA_W     = 8;
    localparam int COMP_W     = 9;
    localparam int ENTRY_W    = 3 * COMP_W;
    localparam int PAIR_W     = 2 * ENTRY_W;
    localparam int LUMA_REG_W = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = 11;
    localparam int RED_SHIFT   = 18;
    localparam int GREEN_SHIFT = 9;
    localparam logic [LUMA_W-1:0] CH_MAX = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LUMA_LO  = 3'd0,
        CFG_LUMA_HI  = 3'd1,
        CFG_ICHR_LO  = 3'd2,
        CFG_ICHR_HI  = 3'd3,
        CFG_QCHR_LO  = 3'd4,
        CFG_QCHR_HI  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LUMA_REG_W-1:0] luma_lo;
        logic [LUMA_REG_W-1:0] luma_hi;
        logic [PAIR_W-1:0]     ichr_lo;
        logic [PAIR_W-1:0]     ichr_hi;
        logic [PAIR_W-1:0]     qchr_lo;
        logic [PAIR_W-1:0]     qchr_hi;
    } t_tables;

    typedef struct packed {
        logic [LUMA_W-1:0]  luma;
        logic [ENTRY_W-1:0] ient;
        logic [ENTRY_W-1:0] qent;
    } t_lookup;

    typedef struct packed {
        logic signed [SUM_W-1:0] red;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] blue;
    } t_sums;

    function automatic logic signed [SUM_W-1:0] comp_ext(input logic [COMP_W-1:0] c);
        comp_ext = $signed({{(SUM_W-COMP_W){c[COMP_W-1]}}, c});
    endfunction

    function automatic logic [LUMA_W-1:0] clamp8(input logic signed [SUM_W-1:0] s);
        if (s[SUM_W-1]) begin
            clamp8 = '0;
        end else if (s[SUM_W-2:LUMA_W] != '0) begin
            clamp8 = CH_MAX;
        end else begin
            clamp8 = s[LUMA_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/ncc_cfg.sv =====
// ncc_cfg: luma and chroma table registers, written through the config port.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_cfg
    import ncc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_tables               o_tables
);

    t_tables r_tables;
    t_tables n_tables;

    always_comb begin
        n_tables = r_tables;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LUMA_LO: n_tables.luma_lo = i_cfg_data;
                CFG_LUMA_HI: n_tables.luma_hi = i_cfg_data;
                CFG_ICHR_LO: n_tables.ichr_lo = i_cfg_data[PAIR_W-1:0];
                CFG_ICHR_HI: n_tables.ichr_hi = i_cfg_data[PAIR_W-1:0];
                CFG_QCHR_LO: n_tables.qchr_lo = i_cfg_data[PAIR_W-1:0];
                CFG_QCHR_HI: n_tables.qchr_hi = i_cfg_data[PAIR_W-1:0];
                default:     n_tables = r_tables;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tables <= '0;
        end else begin
            r_tables <= n_tables;
        end
    end

    assign o_tables = r_tables;

endmodule

// ===== hw/rtl/ncc_lookup.sv =====
// ncc_fetch: stage 1, picks luma byte and the I and Q entries for a texel.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_fetch
    import ncc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tables           i_tables,
    input  logic              i_valid,
    input  logic [LUMA_W-1:0] i_texel,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output t_lookup           o_data
);

    logic    r_valid;
    t_lookup r_data;
    t_lookup n_data;
    logic    w_load;

    logic [LUMA_REG_W-1:0] w_lword;
    logic [PAIR_W-1:0]     w_ipair;
    logic [PAIR_W-1:0]     w_qpair;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        w_lword = i_texel[7] ? i_tables.luma_hi : i_tables.luma_lo;
        w_ipair = i_texel[3] ? i_tables.ichr_hi : i_tables.ichr_lo;
        w_qpair = i_texel[1] ? i_tables.qchr_hi : i_tables.qchr_lo;
        n_data.luma = w_lword[{i_texel[6:4], 3'b000} +: LUMA_W];
        n_data.ient = i_texel[2] ? w_ipair[PAIR_W-1:ENTRY_W] : w_ipair[ENTRY_W-1:0];
        n_data.qent = i_texel[0] ? w_qpair[PAIR_W-1:ENTRY_W] : w_qpair[ENTRY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/ncc_sum.sv =====
// ncc_sum: stage 2, signed luma + I + Q sum per channel.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_sum
    import ncc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_lookup i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_sums   o_sums
);

    logic  r_valid;
    t_sums r_sums;
    t_sums n_sums;
    logic signed [SUM_W-1:0] w_y;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_y = $signed({{(SUM_W-LUMA_W){1'b0}}, i_data.luma});
        n_sums.red   = w_y + comp_ext(i_data.ient[RED_SHIFT +: COMP_W])
                           + comp_ext(i_data.qent[RED_SHIFT +: COMP_W]);
        n_sums.green = w_y + comp_ext(i_data.ient[GREEN_SHIFT +: COMP_W])
                           + comp_ext(i_data.qent[GREEN_SHIFT +: COMP_W]);
        n_sums.blue  = w_y + comp_ext(i_data.ient[COMP_W-1:0])
                           + comp_ext(i_data.qent[COMP_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule

// ===== hw/rtl/ncc_clamp.sv =====
// ncc_clamp: stage 3, saturates each channel to 0..255 into the output register.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_clamp
    import ncc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_sums             i_sums,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [LUMA_W-1:0] o_red,
    output logic [LUMA_W-1:0] o_green,
    output logic [LUMA_W-1:0] o_blue
);

    logic              r_valid;
    logic [LUMA_W-1:0] r_red;
    logic [LUMA_W-1:0] r_green;
    logic [LUMA_W-1:0] r_blue;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_red   <= clamp8(i_sums.red);
            r_green <= clamp8(i_sums.green);
            r_blue  <= clamp8(i_sums.blue);
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== hw/rtl/ncc_texel_decode.sv =====
// ncc_texel_decode: compressed texel to RGB decoder, top level.
// Pipeline: registered lookup, sum and clamp stages between input beat and output valid.
// Throughput: one beat per cycle; each stage moves whenever the next one is free.
// Reset: synchronous, active low; clears stage valid bits and all table registers.
// Depends on ncc_pkg, ncc_cfg, ncc_fetch, ncc_sum, ncc_clamp.
`timescale 1ns / 1ps

module ncc_texel_decode
    import ncc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LUMA_W-1:0]     i_texel,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LUMA_W-1:0]     o_red,
    output logic [LUMA_W-1:0]     o_green,
    output logic [LUMA_W-1:0]     o_blue
);

    t_tables w_tables;
    t_lookup w_s1_data;
    t_sums   w_s2_sums;
    logic    w_s1_valid;
    logic    w_s1_ready;
    logic    w_s2_valid;
    logic    w_s2_ready;

    ncc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_tables   (w_tables)
    );

    ncc_fetch u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tables (w_tables),
        .i_valid  (i_valid),
        .i_texel  (i_texel),
        .o_ready  (o_ready),
        .o_valid  (w_s1_valid),
        .i_ready  (w_s1_ready),
        .o_data   (w_s1_data)
    );

    ncc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_data),
        .o_ready (w_s1_ready),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_sums  (w_s2_sums)
    );

    ncc_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .i_sums  (w_s2_sums),
        .o_ready (w_s2_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    // a stalled sum stage keeps its beat intact
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && !w_s2_ready) |=> (w_s2_valid && $stable(w_s2_sums)))
        else $error("sum stage lost or changed a stalled beat");

    // red and blue sums stay within luma + two signed 9-bit components
    a_s2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_valid |-> (w_s2_sums.red >= -11'sd512 && w_s2_sums.red <= 11'sd765
                     && w_s2_sums.blue >= -11'sd512 && w_s2_sums.blue <= 11'sd765))
        else $error("channel sum out of range");

    // negative green sum moving out must clamp to zero
    a_clamp_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_valid && w_s2_ready && w_s2_sums.green[SUM_W-1]) |=> (o_green == '0))
        else $error("negative green not clamped to zero");

    // input accepted only if the lookup stage has room
    a_s1_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_s1_valid) |-> w_s1_ready)
        else $error("lookup stage overwritten while full");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for ncc_texel_decode.
// Programs the decode tables, streams texels with random idling and checks RGB against
// an in-bench predictor; depends on ncc_pkg and the RTL of ncc_texel_decode.
`timescale 1ns / 1ps

module tb_top;
    import ncc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef struct packed {
        logic [LUMA_W-1:0] red;
        logic [LUMA_W-1:0] green;
        logic [LUMA_W-1:0] blue;
    } t_rgb;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_EVERY4,
        RX_HEAVY
    } t_rx_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [LUMA_W-1:0]     i_texel    = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [LUMA_W-1:0]     o_red;
    logic [LUMA_W-1:0]     o_green;
    logic [LUMA_W-1:0]     o_blue;

    // predictor copy of the decode tables
    logic [LUMA_REG_W-1:0] tbl_luma_lo = '0;
    logic [LUMA_REG_W-1:0] tbl_luma_hi = '0;
    logic [PAIR_W-1:0]     tbl_ichr_lo = '0;
    logic [PAIR_W-1:0]     tbl_ichr_hi = '0;
    logic [PAIR_W-1:0]     tbl_qchr_lo = '0;
    logic [PAIR_W-1:0]     tbl_qchr_hi = '0;

    t_rgb        pending_rgb[$];
    int unsigned cycle_cnt    = 0;
    int unsigned err_cnt      = 0;
    int unsigned texel_cnt    = 0;
    int unsigned rgb_checked  = 0;
    int unsigned table_sets   = 0;
    int          burst_left   = 0;
    t_rx_mode    rx_mode      = RX_OPEN;
    int          rx_left      = 0;

    ncc_texel_decode i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_texel    (i_texel),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [ENTRY_W-1:0] pick_chroma(input logic [PAIR_W-1:0] lo_pair,
                                                       input logic [PAIR_W-1:0] hi_pair,
                                                       input logic [1:0]        sel);
        logic [PAIR_W-1:0] pair;
        pair = sel[1] ? hi_pair : lo_pair;
        return sel[0] ? pair[PAIR_W-1:ENTRY_W] : pair[ENTRY_W-1:0];
    endfunction

    function automatic int comp_value(input logic [COMP_W-1:0] c);
        return c[COMP_W-1] ? int'(c) - 512 : int'(c);
    endfunction

    function automatic logic [LUMA_W-1:0] saturate(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return 8'hff;
        end
        return v[LUMA_W-1:0];
    endfunction

    function automatic t_rgb decode_texel(input logic [LUMA_W-1:0] t);
        logic [LUMA_REG_W-1:0] lw;
        logic [ENTRY_W-1:0]    ie;
        logic [ENTRY_W-1:0]    qe;
        int                    y;
        t_rgb                  px;
        lw = t[7] ? tbl_luma_hi : tbl_luma_lo;
        y  = int'(lw[{t[6:4], 3'b000} +: LUMA_W]);
        ie = pick_chroma(tbl_ichr_lo, tbl_ichr_hi, t[3:2]);
        qe = pick_chroma(tbl_qchr_lo, tbl_qchr_hi, t[1:0]);
        px.red   = saturate(y + comp_value(ie[26:18]) + comp_value(qe[26:18]));
        px.green = saturate(y + comp_value(ie[17:9]) + comp_value(qe[17:9]));
        px.blue  = saturate(y + comp_value(ie[8:0]) + comp_value(qe[8:0]));
        return px;
    endfunction

    // ---------------------------------------------------------------- result check

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rgb.size() == 0) begin
                $error("unexpected beat: red %0h green %0h blue %0h", o_red, o_green, o_blue);
                err_cnt++;
            end else begin
                want = pending_rgb.pop_front();
                rgb_checked++;
                if (o_red !== want.red) begin
                    $error("red: expected %0h, got %0h", want.red, o_red);
                    err_cnt++;
                end
                if (o_green !== want.green) begin
                    $error("green: expected %0h, got %0h", want.green, o_green);
                    err_cnt++;
                end
                if (o_blue !== want.blue) begin
                    $error("blue: expected %0h, got %0h", want.blue, o_blue);
                    err_cnt++;
                end
            end
        end
    end

    // receiver back-pressure; the mode is redrawn at random whenever its countdown runs out
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_LIGHT:  i_ready <= ($urandom_range(0, 9) < 7);
            RX_EVERY4: i_ready <= (cycle_cnt[1:0] == 2'b00);
            default:   i_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_texel(input logic [LUMA_W-1:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_texel <= t;
        do @(posedge i_clk); while (!o_ready);
        pending_rgb.push_back(decode_texel(t));
        texel_cnt++;
    endtask

    // stop sending and let every outstanding beat come back
    task automatic drain_pipe();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_reg(input logic [CFG_IDX_W-1:0]  idx,
                                   input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_LUMA_LO: tbl_luma_lo = data;
            CFG_LUMA_HI: tbl_luma_hi = data;
            CFG_ICHR_LO: tbl_ichr_lo = data[PAIR_W-1:0];
            CFG_ICHR_HI: tbl_ichr_hi = data[PAIR_W-1:0];
            CFG_QCHR_LO: tbl_qchr_lo = data[PAIR_W-1:0];
            CFG_QCHR_HI: tbl_qchr_hi = data[PAIR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_tables(input logic [63:0] luma_lo, input logic [63:0] luma_hi,
                                  input logic [63:0] ichr_lo, input logic [63:0] ichr_hi,
                                  input logic [63:0] qchr_lo, input logic [63:0] qchr_hi);
        write_table_reg(CFG_LUMA_LO, luma_lo);
        write_table_reg(CFG_LUMA_HI, luma_hi);
        write_table_reg(CFG_ICHR_LO, ichr_lo);
        write_table_reg(CFG_ICHR_HI, ichr_hi);
        write_table_reg(CFG_QCHR_LO, qchr_lo);
        write_table_reg(CFG_QCHR_HI, qchr_hi);
        table_sets++;
    endtask

    function automatic logic [ENTRY_W-1:0] pack_entry(input logic [COMP_W-1:0] r,
                                                      input logic [COMP_W-1:0] g,
                                                      input logic [COMP_W-1:0] b);
        return {r, g, b};
    endfunction

    // biased towards the component extremes; spare top bits random
    function automatic logic [63:0] rand_chroma_pair();
        logic [63:0]        v;
        logic [COMP_W-1:0]  c;
        v = {$urandom, $urandom};
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(0, 4))
                0:       c = 9'h0ff;
                1:       c = 9'h100;
                2:       c = 9'h000;
                default: c = COMP_W'($urandom);
            endcase
            v[k*COMP_W +: COMP_W] = c;
        end
        return v;
    endfunction

    function automatic logic [63:0] rand_luma();
        logic [63:0] v;
        v = {$urandom, $urandom};
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 5))
                0:       v[k*8 +: 8] = 8'h00;
                1:       v[k*8 +: 8] = 8'hff;
                default: ;
            endcase
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_tables();
        send_texel(8'h00);
        send_texel(8'hff);
        drain_pipe();
    endtask

    task automatic test_spare_index();
        write_table_reg(CFG_IDX_SPARE_A, '1);
        write_table_reg(CFG_IDX_SPARE_B, '1);
        send_texel(8'h5a);
        send_texel(8'ha5);
        drain_pipe();
    endtask

    task automatic test_luma_select();
        program_tables(64'h8040_2010_0804_02ff, 64'h01fe_dcba_9876_5400,
                       '0, '0, '0, '0);
        send_texel(8'h00);
        send_texel(8'h70);
        send_texel(8'h80);
        send_texel(8'hf0);
        send_texel(8'h35);
        drain_pipe();
    endtask

    // all-ones writes: spare bits dropped, every component reads as -1
    task automatic test_chroma_mask();
        write_table_reg(CFG_ICHR_LO, '1);
        write_table_reg(CFG_QCHR_HI, '1);
        send_texel(8'h01);
        send_texel(8'h84);
        send_texel(8'h0e);
        drain_pipe();
    endtask

    task automatic test_saturation();
        program_tables(64'hffff_ffff_ffff_ffff, 64'h0,
                       64'h0,
                       {10'h0, pack_entry(9'h100, 9'h0ff, 9'h000),
                        pack_entry(9'h0ff, 9'h100, 9'h001)},
                       64'h0,
                       {10'h0, pack_entry(9'h000, 9'h000, 9'h100),
                        pack_entry(9'h0ff, 9'h100, 9'h1ff)});
        send_texel(8'h0a);
        send_texel(8'h8a);
        send_texel(8'h8f);
        send_texel(8'h0f);
        send_texel(8'h8b);
        drain_pipe();
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       program_tables('1, '1, '1, '1, '1, '1);
                1:       program_tables(rand_luma(), rand_luma(), '0, '0, '0, '0);
                default: program_tables(rand_luma(), rand_luma(), rand_chroma_pair(),
                                        rand_chroma_pair(), rand_chroma_pair(),
                                        rand_chroma_pair());
            endcase
            for (int n = 0; n < 80; n++) begin
                send_texel(LUMA_W'($urandom_range(0, 255)));
                if (phase == 3 && n == 40) begin
                    drain_pipe();
                end
            end
            drain_pipe();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_tables();
        test_spare_index();
        test_luma_select();
        test_chroma_mask();
        test_saturation();
        test_random_stream();
        drain_pipe();
        $display("Decoded %0d texels over %0d table settings; %0d beats checked.",
                 texel_cnt, table_sets, rgb_checked);
        $display("Included reset tables, unused indexes, masked writes and clamping.");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_cfg.sv
hw/rtl/ncc_lookup.sv
hw/rtl/ncc_sum.sv
hw/rtl/ncc_clamp.sv
hw/rtl/ncc_texel_decode.sv
dv/tb_top.sv
